>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/rqia_pkg.sv
// ----------------------------------------------------------------------------
// rqia_pkg
// Request modes, controller states and the command and status bundles that
// join the ring queue controller and datapath.
// ----------------------------------------------------------------------------
package rqia_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_GET    = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'b001,
    ST_SHIFT_CHK = 3'b010,
    ST_SHIFT_WR  = 3'b100
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
    logic rd_index;
    logic rd_shift;
    logic shift_wr;
    logic rm_start;
    logic rm_finish;
    logic clear;
    logic res_load;
    logic res_fail;
    logic res_mem;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
    logic more;
  } dp_sts_t;

endpackage

>>> design/rqia_dp.sv
// ----------------------------------------------------------------------------
// rqia_dp
// Ring queue datapath: entry memory, head and tail pointers, entry count,
// remove position counter and result registers.
// ----------------------------------------------------------------------------
module rqia_dp import rqia_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic signed [31:0]   value_i,
  input  logic [3:0]           index_i,
  output logic                 status_o,
  output logic signed [31:0]   value_read_o,
  output logic [4:0]           count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 4) ? CW : 4;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(CAPACITY)) begin
      s = s - (PW+1)'(CAPACITY);
    end
    return s[PW-1:0];
  endfunction

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_q;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] pos_next;
  logic          status_q;
  logic          res_mem_q;
  logic [PW-1:0] rd_off;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  assign pos_next = pos_q + CW'(1);

  assign sts_o.full   = (count_q == CW'(CAPACITY));
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.idx_ok = (XW'(index_i) < XW'(count_q));
  assign sts_o.more   = (pos_next < count_q);

  always_comb begin
    priority if (cmd_i.rd_shift) begin
      rd_off = PW'(pos_next);
    end else if (cmd_i.rd_index) begin
      rd_off = PW'(index_i);
    end else begin
      rd_off = '0;
    end
  end

  assign rd_addr = wrap_add(head_q, rd_off);
  assign wr_en   = cmd_i.push | cmd_i.shift_wr;
  assign wr_addr = cmd_i.shift_wr ? wrap_add(head_q, PW'(pos_q)) : tail_q;
  assign wr_data = cmd_i.shift_wr ? rdata_q : value_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    pos_d   = pos_q;
    priority if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      tail_d  = wrap_add(tail_q, PW'(1));
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      head_d  = wrap_add(head_q, PW'(1));
      count_d = count_q - CW'(1);
    end else if (cmd_i.rm_finish) begin
      tail_d  = wrap_add(tail_q, PW'(CAPACITY - 1));
      count_d = count_q - CW'(1);
    end else if (cmd_i.rm_start) begin
      pos_d = CW'(index_i);
    end else if (cmd_i.shift_wr) begin
      pos_d = pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.res_load) begin
      status_q  <= cmd_i.res_fail;
      res_mem_q <= cmd_i.res_mem;
    end
  end

  assign status_o     = status_q;
  assign value_read_o = res_mem_q ? rdata_q : '0;
  assign count_o      = 5'(count_q);
  assign is_empty_o   = sts_o.empty;
  assign is_full_o    = sts_o.full;

endmodule

>>> design/rqia_ctrl.sv
// ----------------------------------------------------------------------------
// rqia_ctrl
// Ring queue controller: request handshake, decode of the mode, the remove
// shift sequence and the result valid flag.
// ----------------------------------------------------------------------------
module rqia_ctrl import rqia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_PUSH: begin
              cmd_o.push     = !sts_i.full;
              cmd_o.res_fail = sts_i.full;
            end
            MODE_POP: begin
              cmd_o.pop      = !sts_i.empty;
              cmd_o.rd_en    = !sts_i.empty;
              cmd_o.res_mem  = !sts_i.empty;
              cmd_o.res_fail = sts_i.empty;
            end
            MODE_PEEK: begin
              cmd_o.rd_en    = !sts_i.empty;
              cmd_o.res_mem  = !sts_i.empty;
              cmd_o.res_fail = sts_i.empty;
            end
            MODE_GET: begin
              cmd_o.rd_en    = sts_i.idx_ok;
              cmd_o.rd_index = 1'b1;
              cmd_o.res_mem  = sts_i.idx_ok;
              cmd_o.res_fail = !sts_i.idx_ok;
            end
            MODE_REMOVE: begin
              if (sts_i.idx_ok) begin
                cmd_o.res_load = 1'b0;
                cmd_o.rm_start = 1'b1;
                state_d        = ST_SHIFT_CHK;
              end else begin
                cmd_o.res_fail = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
              cmd_o.res_fail = 1'b1;
            end
          endcase
        end
      end
      ST_SHIFT_CHK: begin
        if (sts_i.more) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_shift = 1'b1;
          state_d        = ST_SHIFT_WR;
        end else begin
          cmd_o.rm_finish = 1'b1;
          cmd_o.res_load  = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = ST_SHIFT_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/ring_queue_with_indexed_access.sv
// ----------------------------------------------------------------------------
// ring_queue_with_indexed_access
// Fixed-capacity ring queue of signed 32-bit words with indexed access.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid_i/in_stall_o with mode_i, value_i and index_i.
// Each request yields one result on out_valid_o/out_stall_i with status_o,
// value_read_o and the count, empty and full flags after the request.
// Push, pop, peek, get, clear and unused modes give their result in the cycle
// after the request is taken, so one request per cycle is sustained while
// the receiver takes results at once.
// A successful remove moves each later entry one place toward the head,
// reading it in ST_SHIFT_CHK and writing it in ST_SHIFT_WR, so its result
// appears once the last entry has moved; no request is taken meanwhile.
// The result sits in an output register; while the receiver stalls it holds,
// and a new request is taken only at the edge where that result leaves.
// Reset clears the pointers, the count and the result valid flag; entry
// contents are not cleared and become defined when pushed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_queue_with_indexed_access import rqia_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          mode_i,
  input  logic signed [31:0]  value_i,
  input  logic [3:0]          index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                status_o,
  output logic signed [31:0]  value_read_o,
  output logic [4:0]          count_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rqia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rqia_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .index_i      (index_i),
    .status_o     (status_o),
    .value_read_o (value_read_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  `ASSERT_NEVER(a_accept_over_held_result, in_valid_i && !in_stall_o && out_valid_o && out_stall_i, "request taken while a stalled result is held")
  `ASSERT_HOLDS(a_short_request_result, (in_valid_i && !in_stall_o && mode_i != MODE_REMOVE) |=> out_valid_o, "no result after a single-cycle request")
  `ASSERT_HOLDS(a_busy_no_result, (in_stall_o && !out_stall_i) |-> !out_valid_o, "result shown while a remove is still shifting")

endmodule

>>> bench/ring_queue_checker.sv
// ----------------------------------------------------------------------------
// ring_queue_checker
// Watches the request and result channels of the ring queue, keeps its own
// copy of the queue contents and pointers, and compares every result field
// against the prediction for the oldest outstanding request.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ring_queue_checker import rqia_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               status_i,
  input  logic signed [31:0] value_read_i,
  input  logic [4:0]         count_i,
  input  logic               is_empty_i,
  input  logic               is_full_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int DEPTH = 16;

  typedef struct packed {
    logic               status;
    logic signed [31:0] value_read;
    logic [4:0]         count;
    logic               is_empty;
    logic               is_full;
  } queue_result_t;

  logic signed [31:0] word_mem [DEPTH];
  int                 head_pos;
  int                 tail_pos;
  int                 held;
  int                 fail_count = 0;
  int                 pending = 0;
  queue_result_t      expected_results [$];

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic apply_request(input logic [2:0] mode, input logic signed [31:0] value,
                               input logic [3:0] index, output queue_result_t res);
    res.status     = 1'b1;
    res.value_read = '0;
    case (mode)
      MODE_PUSH: begin
        if (held < DEPTH) begin
          word_mem[tail_pos] = value;
          tail_pos = (tail_pos + 1) % DEPTH;
          held++;
          res.status = 1'b0;
        end
      end
      MODE_POP: begin
        if (held != 0) begin
          res.value_read = word_mem[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
          res.status = 1'b0;
        end
      end
      MODE_PEEK: begin
        if (held != 0) begin
          res.value_read = word_mem[head_pos];
          res.status = 1'b0;
        end
      end
      MODE_GET: begin
        if (int'(index) < held) begin
          res.value_read = word_mem[(head_pos + int'(index)) % DEPTH];
          res.status = 1'b0;
        end
      end
      MODE_REMOVE: begin
        if (int'(index) < held) begin
          for (int i = int'(index); i + 1 < held; i++) begin
            word_mem[(head_pos + i) % DEPTH] = word_mem[(head_pos + i + 1) % DEPTH];
          end
          tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
          held--;
          res.status = 1'b0;
        end
      end
      MODE_CLEAR: begin
        head_pos = 0;
        tail_pos = 0;
        held = 0;
        res.status = 1'b0;
      end
      default: begin
      end
    endcase
    res.count    = held[4:0];
    res.is_empty = (held == 0);
    res.is_full  = (held == DEPTH);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t predicted;
    queue_result_t oldest;
    if (!rst_ni) begin
      head_pos = 0;
      tail_pos = 0;
      held = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          oldest = expected_results.pop_front();
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0b, expected %0b",
                                      status_i, oldest.status));
          if (value_read_i !== oldest.value_read)
            report_mismatch($sformatf("value_read got %0d, expected %0d",
                                      value_read_i, oldest.value_read));
          if (count_i !== oldest.count)
            report_mismatch($sformatf("count got %0d, expected %0d",
                                      count_i, oldest.count));
          if (is_empty_i !== oldest.is_empty)
            report_mismatch($sformatf("is_empty got %0b, expected %0b",
                                      is_empty_i, oldest.is_empty));
          if (is_full_i !== oldest.is_full)
            report_mismatch($sformatf("is_full got %0b, expected %0b",
                                      is_full_i, oldest.is_full));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(mode_i, value_i, index_i, predicted);
        expected_results.push_back(predicted);
      end
      pending = expected_results.size();
    end
  end

endmodule

>>> bench/tb_ring_queue_with_indexed_access.sv
// ----------------------------------------------------------------------------
// tb_ring_queue_with_indexed_access
// Drives the ring queue with a directed sequence of corner requests followed
// by phased random traffic in bursts, while the result side stalls on its own
// changing pattern. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ring_queue_with_indexed_access import rqia_pkg::*;;

  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
  localparam int         RANDOM_REQUESTS = 750;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = MODE_CLEAR;
  logic signed [31:0] value = '0;
  logic [3:0]         index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic signed [31:0] value_read;
  logic [4:0]         count;
  logic               is_empty;
  logic               is_full;
  int                 fail_count;
  int                 pending;
  int                 stall_pattern = 0;
  int                 pattern_left = 0;

  ring_queue_with_indexed_access dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .value_i      (value),
    .index_i      (index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .value_read_o (value_read),
    .count_o      (count),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full)
  );

  ring_queue_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .value_i      (value),
    .index_i      (index),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .value_read_i (value_read),
    .count_i      (count),
    .is_empty_i   (is_empty),
    .is_full_i    (is_full),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (pattern_left == 0) begin
      stall_pattern <= $urandom_range(0, 3);
      pattern_left  <= $urandom_range(16, 96);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    case (stall_pattern)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic send_request(input logic [2:0] m, input logic signed [31:0] v,
                              input logic [3:0] idx);
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    index    <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_mode(input int bias);
    int r;
    r = $urandom_range(0, 99);
    case (bias)
      0: begin
        if (r < 60) return MODE_PUSH;
        if (r < 70) return MODE_POP;
        if (r < 78) return MODE_PEEK;
        if (r < 88) return MODE_GET;
        if (r < 96) return MODE_REMOVE;
        if (r < 98) return MODE_CLEAR;
      end
      1: begin
        if (r < 20) return MODE_PUSH;
        if (r < 50) return MODE_POP;
        if (r < 58) return MODE_PEEK;
        if (r < 70) return MODE_GET;
        if (r < 96) return MODE_REMOVE;
        if (r < 97) return MODE_CLEAR;
      end
      default: begin
        if (r < 35) return MODE_PUSH;
        if (r < 50) return MODE_POP;
        if (r < 60) return MODE_PEEK;
        if (r < 78) return MODE_GET;
        if (r < 94) return MODE_REMOVE;
        if (r < 97) return MODE_CLEAR;
      end
    endcase
    return $urandom_range(0, 1) ? MODE_UNUSED_7 : MODE_UNUSED_6;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int sent;
    int bias;
    int burst_len;
    int gap;
    logic [3:0] idx;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A clear, failing requests on an empty queue, then the unused modes.
    send_request(MODE_CLEAR,    32'sd0, 4'd0);
    send_request(MODE_POP,      32'sd0, 4'd0);
    send_request(MODE_PEEK,     32'sd0, 4'd0);
    send_request(MODE_GET,      32'sd0, 4'd0);
    send_request(MODE_REMOVE,   32'sd0, 4'd0);
    send_request(MODE_UNUSED_6, 32'sd5, 4'd15);
    send_request(MODE_UNUSED_7, 32'sd9, 4'd15);
    send_request(MODE_PUSH,     32'sh8000_0000, 4'd15);
    send_request(MODE_PUSH,     32'sh7fff_ffff, 4'd0);
    send_request(MODE_PUSH,     32'sh0000_0000, 4'd0);
    send_request(MODE_PUSH,     32'shffff_ffff, 4'd0);
    send_request(MODE_PEEK,     32'sd0, 4'd0);
    send_request(MODE_GET,      32'sd0, 4'd3);
    send_request(MODE_GET,      32'sd0, 4'd4);
    send_request(MODE_REMOVE,   32'sd0, 4'd4);
    send_request(MODE_REMOVE,   32'sd0, 4'd1);
    send_request(MODE_REMOVE,   32'sd0, 4'd2);
    send_request(MODE_REMOVE,   32'sd0, 4'd0);
    send_request(MODE_POP,      32'sd0, 4'd0);
    send_request(MODE_POP,      32'sd0, 4'd0);
    send_request(MODE_CLEAR,    32'sd0, 4'd0);

    // Phased random traffic: fill-heavy, drain-heavy and mixed stretches.
    sent = 0;
    bias = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(1, 24);
      for (int b = 0; b < burst_len && sent < RANDOM_REQUESTS; b++) begin
        if (sent % 40 == 0) bias = $urandom_range(0, 2);
        idx = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
        send_request(pick_mode(bias), pick_value(), idx);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // The checker counts the last request at the edge just passed.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
